[design/afuh_pkg.sv]
// Package for the audio byte FIFO with underrun hold.
// Holds shared constants, the controller state type and the command and status structs.
// Depends on nothing.
package afuh_pkg;

  localparam int unsigned DepthDefault = 4096;
  localparam int unsigned LanesDefault = 4;

  // Field widths fixed by the interface.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LaneInW = 2;
  localparam int unsigned LimitW  = 13;
  localparam int unsigned CountW  = 32;

  localparam logic [LimitW-1:0] LimitReset = 13'd4096;

  // Item command codes.
  localparam logic CmdPush = 1'b0;
  localparam logic CmdPull = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_EXEC,
    ST_READ
  } afuh_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch_item;  // capture accepted item
    logic clamp;       // trim occupancy to the limit
    logic push;        // write byte, advance write pointer
    logic pull_hit;    // issue store read, advance read pointer
    logic underrun;    // emit held byte, bump count
    logic hit_out;     // emit read byte, refresh hold
  } afuh_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pull;
    logic empty;
    logic out_free;
  } afuh_status_t;

endpackage

[design/afuh_ctrl.sv]
// Controller state machine for the audio byte FIFO.
// Sequences clamp, execute and read steps of one item at a time.
// Depends on afuh_pkg.
module afuh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  afuh_pkg::afuh_status_t status_i,
  output afuh_pkg::afuh_cmd_t    cmd_o
);
  import afuh_pkg::*;

  afuh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (!status_i.is_pull) begin
          state_d = ST_IDLE;
        end else if (!status_i.empty) begin
          state_d = ST_READ;
        end else if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.latch_item = in_valid_i;
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
      end
      ST_EXEC: begin
        priority if (!status_i.is_pull) begin
          cmd_o.push = 1'b1;
        end else if (!status_i.empty) begin
          cmd_o.pull_hit = 1'b1;
        end else begin
          cmd_o.underrun = status_i.out_free;
        end
      end
      ST_READ: begin
        cmd_o.hit_out = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

[design/afuh_dp.sv]
// Datapath for the audio byte FIFO: byte store, pointers, occupancy,
// lane hold bytes, underrun count and the output register. Depends on afuh_pkg.
module afuh_dp #(
  parameter int unsigned DEPTH = afuh_pkg::DepthDefault,
  parameter int unsigned LANES = afuh_pkg::LanesDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  afuh_pkg::afuh_cmd_t                 cmd_i,
  output afuh_pkg::afuh_status_t              status_o,
  input  logic                               command_i,
  input  logic [afuh_pkg::ByteW-1:0]          data_byte_i,
  input  logic [afuh_pkg::LaneInW-1:0]        lane_i,
  input  logic                               fill_limit_we_i,
  input  logic [afuh_pkg::LimitW-1:0]         fill_limit_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [afuh_pkg::ByteW-1:0]          sample_byte_o,
  output logic                               underrun_o,
  output logic [afuh_pkg::CountW-1:0]         underrun_total_o
);
  import afuh_pkg::*;

  localparam int unsigned PtrW  = $clog2(DEPTH);
  localparam int unsigned OccW  = $clog2(DEPTH + 1);
  localparam int unsigned SumW  = OccW + 1;
  localparam int unsigned CmpW  = (OccW > LimitW) ? OccW : LimitW;
  localparam int unsigned LaneW = (LANES > 1) ? $clog2(LANES) : 1;

  localparam logic [PtrW-1:0] PtrLast  = PtrW'(DEPTH - 1);
  localparam logic [OccW-1:0] OccFull  = OccW'(DEPTH);
  localparam logic [CmpW-1:0] DepthCmp = CmpW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);
  localparam logic [3:0]      LanesN   = 4'(LANES);

  logic [ByteW-1:0]   mem_q [DEPTH];
  logic [ByteW-1:0]   rdata_q;
  logic [PtrW-1:0]    rd_ptr_q, wr_ptr_q;
  logic [OccW-1:0]    occ_q;
  logic [LimitW-1:0]  limit_q;
  logic               cmd_q;
  logic [ByteW-1:0]   byte_q;
  logic [LaneW-1:0]   lane_q;
  logic [ByteW-1:0]   hold_q [LANES];
  logic [CountW-1:0]  count_q;
  logic               out_valid_q;
  logic [ByteW-1:0]   out_byte_q;
  logic               out_flag_q;

  logic [OccW-1:0]    lim_sat;
  logic [OccW-1:0]    drop;
  logic [SumW-1:0]    rp_sum;
  logic [PtrW-1:0]    rp_clamped;
  logic [PtrW-1:0]    rp_inc, wp_inc;
  logic [LaneW-1:0]   lane_sel;
  logic               out_load;

  // Lane index modulo LANES, at most four subtract steps on a 4-bit value.
  always_comb begin
    logic [3:0] t;
    t = {2'b00, lane_i};
    for (int k = 0; k < 4; k++) begin
      if (t >= LanesN) t = t - LanesN;
    end
    lane_sel = LaneW'(t);
  end

  // Clamp arithmetic: saturate limit to DEPTH, then skip the excess oldest bytes.
  always_comb begin
    lim_sat = (CmpW'(limit_q) > DepthCmp) ? OccFull : OccW'(limit_q);
    drop    = occ_q - lim_sat;
    rp_sum  = SumW'(rd_ptr_q) + SumW'(drop);
    if (rp_sum >= DepthSum) rp_sum = rp_sum - DepthSum;
    rp_clamped = rp_sum[PtrW-1:0];
  end

  assign rp_inc = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
  assign wp_inc = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;

  assign out_load = cmd_i.underrun | cmd_i.hit_out;

  assign status_o.is_pull  = (cmd_q == CmdPull);
  assign status_o.empty    = (occ_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Byte store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[wr_ptr_q] <= byte_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pull_hit) rdata_q <= mem_q[rd_ptr_q];
  end

  // Latched item fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      cmd_q  <= command_i;
      byte_q <= data_byte_i;
      lane_q <= lane_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (fill_limit_we_i) begin
      limit_q <= fill_limit_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      if (cmd_i.clamp && (occ_q > lim_sat)) begin
        rd_ptr_q <= rp_clamped;
        occ_q    <= lim_sat;
      end
      if (cmd_i.push) begin
        wr_ptr_q <= wp_inc;
        // full: drop the oldest, occupancy stays
        if (occ_q == OccFull) begin
          rd_ptr_q <= rp_inc;
        end else begin
          occ_q <= occ_q + 1'b1;
        end
      end
      if (cmd_i.pull_hit) begin
        rd_ptr_q <= rp_inc;
        occ_q    <= occ_q - 1'b1;
      end
    end
  end

  // Hold bytes and underrun count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) hold_q[i] <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.hit_out) hold_q[lane_q] <= rdata_q;
      if (cmd_i.underrun && (count_q != '1)) count_q <= count_q + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= cmd_i.underrun ? hold_q[lane_q] : rdata_q;
      out_flag_q <= cmd_i.underrun;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_byte_o    = out_byte_q;
  assign underrun_o       = out_flag_q;
  // The count moves only when a new result loads, so it tracks the shown item.
  assign underrun_total_o = count_q;

endmodule

[design/audio_fifo_with_underrun_hold_core.sv]
// Audio byte FIFO with a latency cap and underrun hold: one item at a time.
// Push: accept, clamp, write. Pull: accept, clamp, then the underrun result or a store read
// and the read result; the result shows in the output register in the cycle after the last
// step. A new item is taken only once the last is through the clamp/execute/read sequence
// around the single-port byte store. Reset is asynchronous, active low: pointers, occupancy,
// hold bytes and count clear, fill limit returns to 4096; store is not cleared.
module audio_fifo_with_underrun_hold_core #(
  parameter int unsigned DEPTH = afuh_pkg::DepthDefault,
  parameter int unsigned LANES = afuh_pkg::LanesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [afuh_pkg::ByteW-1:0]     data_byte_i,
  input  logic [afuh_pkg::LaneInW-1:0]   lane_i,
  // fill limit register
  input  logic                          fill_limit_we_i,
  input  logic [afuh_pkg::LimitW-1:0]    fill_limit_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [afuh_pkg::ByteW-1:0]     sample_byte_o,
  output logic                          underrun_o,
  output logic [afuh_pkg::CountW-1:0]    underrun_total_o
);
  import afuh_pkg::*;

  afuh_cmd_t    cmd;
  afuh_status_t status;

  // Controller: walks each item through clamp, execute and, on a pull
  // that finds data, a read step. On a pull it waits in place while the
  // output register still holds an untaken result.
  afuh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: the circular byte store with its pointers, the clamp
  // arithmetic, per-lane hold bytes, the saturating underrun count and
  // the output register that decouples the result side.
  afuh_dp #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .command_i        (command_i),
    .data_byte_i      (data_byte_i),
    .lane_i           (lane_i),
    .fill_limit_we_i  (fill_limit_we_i),
    .fill_limit_i     (fill_limit_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_byte_o    (sample_byte_o),
    .underrun_o       (underrun_o),
    .underrun_total_o (underrun_total_o)
  );

endmodule

[design/afuh_checker.sv]
// Port-level checks for the audio byte FIFO, bound to the top level.
// Depends on afuh_pkg and audio_fifo_with_underrun_hold_core.
module afuh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [afuh_pkg::ByteW-1:0]     sample_byte_o,
  input logic                          underrun_o,
  input logic [afuh_pkg::CountW-1:0]    underrun_total_o
);
  import afuh_pkg::*;

  // A stalled result stays up.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(sample_byte_o) && $stable(underrun_o) && $stable(underrun_total_o))
    else $error("result payload changed while stalled");

  // An accepted item keeps the input side busy the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after accept");

  // The underrun count never goes down.
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> underrun_total_o >= $past(underrun_total_o))
    else $error("underrun count decreased");

  // An underrun result always carries a nonzero count.
  a_flag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && underrun_o |-> underrun_total_o != '0)
    else $error("underrun flagged with zero count");

endmodule

bind audio_fifo_with_underrun_hold_core afuh_checker u_afuh_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .sample_byte_o    (sample_byte_o),
  .underrun_o       (underrun_o),
  .underrun_total_o (underrun_total_o)
);
